// ----- rtl/tbm_pkg.sv -----
package tbm_pkg;

  // Field and datapath widths
  localparam int FREQ_W     = 13;   // melody note frequency register
  localparam int MS_W       = 16;   // duration in ms
  localparam int IN_F_W     = 16;   // play command frequency
  localparam int CMD_W      = 2;
  localparam int NOTE_W     = 2;
  localparam int NOTE_SLOTS = 4;
  localparam int HALF_W     = 14;   // half period in ticks, at most 10000
  localparam int TOG_W      = 20;   // toggle counters
  localparam int TWO_F_W    = FREQ_W + 1;
  localparam int PROD_W     = TWO_F_W + MS_W;
  localparam int QUO_W      = 20;   // dividend width of the half period division
  localparam int CNT_W      = $clog2(QUO_W);
  localparam int RECIP_W    = 31;
  localparam int RECIP_SHIFT = 40;
  localparam int RPROD_W    = PROD_W + RECIP_W;

  localparam int NOTE_COUNT_DEF = 4;

  localparam logic [IN_F_W-1:0] FREQ_MIN = 16'd50;
  localparam logic [IN_F_W-1:0] FREQ_MAX = 16'd5000;
  localparam logic [QUO_W-1:0]  TICKS_PER_SEC = 20'd1000000;
  // ceil(2^40 / 1000): exact floor(p / 1000) for every product p below 2^30
  localparam logic [RECIP_W-1:0] RECIP_1000 = 31'd1099511628;

  // APB register map
  localparam int ADDR_W    = 5;
  localparam int REG_IDX_W = 3;
  localparam int DATA_W    = 32;
  localparam logic [REG_IDX_W-1:0] REG_MS_FIRST = 3'd4;

  typedef logic [FREQ_W-1:0] freq_t;
  typedef logic [MS_W-1:0]   ms_t;

  localparam freq_t NOTE_FREQ_RST [NOTE_SLOTS] = '{13'd1047, 13'd1319, 13'd1568, 13'd2093};
  localparam ms_t   NOTE_MS_RST   [NOTE_SLOTS] = '{16'd150, 16'd150, 16'd150, 16'd250};

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK   = 2'd0,
    CMD_PLAY   = 2'd1,
    CMD_MELODY = 2'd2,
    CMD_STOP   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_START,
    S_DIV,
    S_COMMIT,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic latch;
    logic pin_low;
    logic tick_adv;
    logic tick_toggle;
    logic halt;
    logic end_mel;
    logic note_adv;
    logic mel_start;
    logic set_ign;
    logic launch;
    logic recip;
    logic commit;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic busy;
    logic mel;
    logic tick_wrap;
    logic toggle_end;
    logic last_note;
    logic zero_tone;
    logic div_idle;
    logic out_free;
  } dp_stat_t;

endpackage

// ----- rtl/tbm_ifs.sv -----
interface tbm_item_if;
  logic                        valid;
  logic                        ready;
  logic [tbm_pkg::CMD_W-1:0]   command;
  logic [tbm_pkg::IN_F_W-1:0]  freq_hz;
  logic [tbm_pkg::MS_W-1:0]    duration_ms;

  modport source (output valid, command, freq_hz, duration_ms, input ready);
  modport sink   (input valid, command, freq_hz, duration_ms, output ready);
endinterface

interface tbm_result_if;
  logic                        valid;
  logic                        ready;
  logic                        pin_level;
  logic                        busy_res;
  logic                        melody_active;
  logic [tbm_pkg::NOTE_W-1:0]  note_index;
  logic                        ignored;

  modport source (output valid, pin_level, busy_res, melody_active, note_index, ignored,
                  input ready);
  modport sink   (input valid, pin_level, busy_res, melody_active, note_index, ignored,
                  output ready);
endinterface

// ----- rtl/tbm_div.sv -----
module tbm_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [tbm_pkg::TWO_F_W-1:0]  divisor,
  output logic [tbm_pkg::QUO_W-1:0]    quotient,
  output logic                         idle
);

  logic                          run;
  logic [tbm_pkg::CNT_W-1:0]     cnt;
  logic [tbm_pkg::TWO_F_W-1:0]   rem;
  logic [tbm_pkg::QUO_W-1:0]     quo;
  logic [tbm_pkg::TWO_F_W:0]     shifted;
  logic [tbm_pkg::TWO_F_W:0]     diff;
  logic                          fits;

  // one quotient bit per cycle, restoring
  assign shifted = {rem, quo[tbm_pkg::QUO_W-1]};
  assign fits    = shifted >= {1'b0, divisor};
  assign diff    = shifted - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      run <= 1'b1;
      cnt <= '0;
      rem <= '0;
      quo <= tbm_pkg::TICKS_PER_SEC;
    end else if (run) begin
      rem <= fits ? diff[tbm_pkg::TWO_F_W-1:0] : shifted[tbm_pkg::TWO_F_W-1:0];
      quo <= {quo[tbm_pkg::QUO_W-2:0], fits};
      cnt <= cnt + 1'b1;
      if (cnt == tbm_pkg::CNT_W'(tbm_pkg::QUO_W - 1)) begin
        run <= 1'b0;
      end
    end
  end

  assign quotient = quo;
  assign idle     = !run;

endmodule

// ----- rtl/tbm_dp.sv -----
module tbm_dp #(
  parameter int NOTE_COUNT = tbm_pkg::NOTE_COUNT_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  tbm_pkg::dp_cmd_t             cmd,
  output tbm_pkg::dp_stat_t            stat,
  input  logic [tbm_pkg::CMD_W-1:0]    command,
  input  logic [tbm_pkg::IN_F_W-1:0]   freq_hz,
  input  logic [tbm_pkg::MS_W-1:0]     duration_ms,
  input  tbm_pkg::freq_t               note_freq [tbm_pkg::NOTE_SLOTS],
  input  tbm_pkg::ms_t                 note_ms   [tbm_pkg::NOTE_SLOTS],
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic                         pin_level,
  output logic                         busy_res,
  output logic                         melody_active,
  output logic [tbm_pkg::NOTE_W-1:0]   note_index,
  output logic                         ignored
);

  localparam int NC_W = tbm_pkg::NOTE_W + 1;
  localparam logic [NC_W-1:0] NOTE_END = NC_W'(NOTE_COUNT);

  tbm_pkg::cmd_t                    cmd_q;
  logic [tbm_pkg::IN_F_W-1:0]       f_q;
  logic [tbm_pkg::MS_W-1:0]         ms_q;
  logic                             ign;

  logic                             pin;
  logic                             busy;
  logic                             mel;
  logic [tbm_pkg::NOTE_W-1:0]       note;
  logic [tbm_pkg::HALF_W-1:0]       tick_cnt;
  logic [tbm_pkg::HALF_W-1:0]       half;
  logic [tbm_pkg::TOG_W-1:0]        done;
  logic [tbm_pkg::TOG_W-1:0]        target;

  logic [tbm_pkg::PROD_W-1:0]       prod;
  logic [tbm_pkg::RPROD_W-1:0]      rprod;

  logic [tbm_pkg::HALF_W-1:0]       tick_next;
  logic [tbm_pkg::TOG_W-1:0]        done_next;
  logic [NC_W-1:0]                  note_after;
  logic [tbm_pkg::IN_F_W-1:0]       sel_f;
  logic [tbm_pkg::MS_W-1:0]         sel_ms;
  logic [tbm_pkg::FREQ_W-1:0]       fc;
  logic [tbm_pkg::TWO_F_W-1:0]      two_f;
  logic [tbm_pkg::QUO_W-1:0]        quo;
  logic                             div_idle;
  logic [tbm_pkg::RPROD_W-tbm_pkg::RECIP_SHIFT-1:0] cnt_raw;
  logic [tbm_pkg::TOG_W-1:0]        target_new;

  assign tick_next  = tick_cnt + 1'b1;
  assign done_next  = done + 1'b1;
  assign note_after = {1'b0, note} + 1'b1;

  // a play command takes its operands from the word, a melody note from its registers
  assign sel_f  = (cmd_q == tbm_pkg::CMD_PLAY) ? f_q  : tbm_pkg::IN_F_W'(note_freq[note]);
  assign sel_ms = (cmd_q == tbm_pkg::CMD_PLAY) ? ms_q : note_ms[note];

  always_comb begin
    priority if (sel_f < tbm_pkg::FREQ_MIN) begin
      fc = tbm_pkg::FREQ_MIN[tbm_pkg::FREQ_W-1:0];
    end else if (sel_f > tbm_pkg::FREQ_MAX) begin
      fc = tbm_pkg::FREQ_MAX[tbm_pkg::FREQ_W-1:0];
    end else begin
      fc = sel_f[tbm_pkg::FREQ_W-1:0];
    end
  end

  assign two_f = {fc, 1'b0};

  tbm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.launch),
    .divisor  (two_f),
    .quotient (quo),
    .idle     (div_idle)
  );

  // floor(2f * ms / 1000) by reciprocal, never below one toggle
  assign cnt_raw    = rprod[tbm_pkg::RPROD_W-1:tbm_pkg::RECIP_SHIFT];
  assign target_new = (cnt_raw == '0) ? tbm_pkg::TOG_W'(1) : cnt_raw[tbm_pkg::TOG_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      pin       <= 1'b0;
      busy      <= 1'b0;
      mel       <= 1'b0;
      note      <= '0;
      tick_cnt  <= '0;
      half      <= '0;
      done      <= '0;
      target    <= '0;
      ign       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.latch) begin
        cmd_q <= tbm_pkg::cmd_t'(command);
        f_q   <= freq_hz;
        ms_q  <= duration_ms;
        ign   <= 1'b0;
      end
      if (cmd.set_ign) begin
        ign <= 1'b1;
      end
      if (cmd.pin_low) begin
        pin <= 1'b0;
      end
      if (cmd.tick_adv) begin
        tick_cnt <= tick_next;
      end
      if (cmd.tick_toggle) begin
        tick_cnt <= '0;
        pin      <= ~pin;
        done     <= done_next;
      end
      if (cmd.halt || cmd.end_mel) begin
        pin      <= 1'b0;
        busy     <= 1'b0;
        tick_cnt <= '0;
        half     <= '0;
        done     <= '0;
        target   <= '0;
      end
      if (cmd.end_mel) begin
        mel  <= 1'b0;
        note <= '0;
      end
      if (cmd.note_adv) begin
        note <= note_after[tbm_pkg::NOTE_W-1:0];
      end
      if (cmd.mel_start) begin
        mel  <= 1'b1;
        note <= '0;
      end
      if (cmd.launch) begin
        prod <= tbm_pkg::PROD_W'(two_f) * tbm_pkg::PROD_W'(sel_ms);
      end
      if (cmd.recip) begin
        rprod <= tbm_pkg::RPROD_W'(prod) * tbm_pkg::RPROD_W'(tbm_pkg::RECIP_1000);
      end
      if (cmd.commit) begin
        half     <= quo[tbm_pkg::HALF_W-1:0];
        tick_cnt <= '0;
        done     <= '0;
        target   <= target_new;
        busy     <= 1'b1;
      end
      if (cmd.emit) begin
        out_valid     <= 1'b1;
        pin_level     <= pin;
        busy_res      <= busy;
        melody_active <= mel;
        note_index    <= note;
        ignored       <= ign;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign stat.cmd        = cmd_q;
  assign stat.busy       = busy;
  assign stat.mel        = mel;
  assign stat.tick_wrap  = tick_next >= half;
  assign stat.toggle_end = done_next >= target;
  assign stat.last_note  = note_after >= NOTE_END;
  assign stat.zero_tone  = (sel_f == '0) || (sel_ms == '0);
  assign stat.div_idle   = div_idle;
  assign stat.out_free   = !out_valid || out_ready;

endmodule

// ----- rtl/tbm_ctrl.sv -----
module tbm_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  tbm_pkg::dp_stat_t   stat,
  output tbm_pkg::dp_cmd_t    cmd
);

  tbm_pkg::state_t state;
  tbm_pkg::state_t state_next;
  logic            can_start;
  logic            tick_note;
  logic            go_start;

  // a tone ends on this tick and the melody moves on to its next note
  assign tick_note = stat.busy && stat.tick_wrap && stat.toggle_end && stat.mel &&
                     !stat.last_note;
  assign can_start = !stat.busy && !stat.mel;

  always_comb begin
    unique case (stat.cmd)
      tbm_pkg::CMD_TICK:   go_start = tick_note;
      tbm_pkg::CMD_PLAY:   go_start = can_start;
      tbm_pkg::CMD_MELODY: go_start = can_start;
      tbm_pkg::CMD_STOP:   go_start = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tbm_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      tbm_pkg::S_IDLE: begin
        if (in_valid) state_next = tbm_pkg::S_EXEC;
      end
      tbm_pkg::S_EXEC: begin
        state_next = go_start ? tbm_pkg::S_START : tbm_pkg::S_EMIT;
      end
      tbm_pkg::S_START: begin
        state_next = stat.zero_tone ? tbm_pkg::S_EMIT : tbm_pkg::S_DIV;
      end
      tbm_pkg::S_DIV: begin
        if (stat.div_idle) state_next = tbm_pkg::S_COMMIT;
      end
      tbm_pkg::S_COMMIT: begin
        state_next = tbm_pkg::S_EMIT;
      end
      tbm_pkg::S_EMIT: begin
        if (stat.out_free) state_next = tbm_pkg::S_IDLE;
      end
      default: state_next = tbm_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = (state == tbm_pkg::S_IDLE);
    unique case (state)
      tbm_pkg::S_IDLE: begin
        cmd.latch = in_valid;
      end
      tbm_pkg::S_EXEC: begin
        unique case (stat.cmd)
          tbm_pkg::CMD_TICK: begin
            priority if (!stat.busy) begin
              cmd.pin_low = 1'b1;
            end else if (!stat.tick_wrap) begin
              cmd.tick_adv = 1'b1;
            end else if (!stat.toggle_end) begin
              cmd.tick_toggle = 1'b1;
            end else if (tick_note) begin
              cmd.halt     = 1'b1;
              cmd.note_adv = 1'b1;
            end else begin
              cmd.end_mel = 1'b1;
            end
          end
          tbm_pkg::CMD_PLAY: begin
            cmd.set_ign = !can_start;
          end
          tbm_pkg::CMD_MELODY: begin
            cmd.set_ign   = !can_start;
            cmd.mel_start = can_start;
          end
          tbm_pkg::CMD_STOP: begin
            cmd.end_mel = 1'b1;
          end
        endcase
      end
      tbm_pkg::S_START: begin
        // zero frequency or duration stops output and ends any melody
        cmd.end_mel = stat.zero_tone;
        cmd.launch  = !stat.zero_tone;
      end
      tbm_pkg::S_DIV: begin
        cmd.recip = stat.div_idle;
      end
      tbm_pkg::S_COMMIT: begin
        cmd.commit = 1'b1;
      end
      tbm_pkg::S_EMIT: begin
        cmd.emit = stat.out_free;
      end
      default: cmd = '0;
    endcase
  end

endmodule

// ----- rtl/buzzer_tone_melody_player.sv -----
// Square-wave buzzer driver with a melody sequencer. Each word on the item
// channel is one command: a 1 us tick, play a tone, start the melody, or stop,
// and each gives exactly one result word with the pin level, tone and melody
// flags, the current note and an ignored flag. Play takes a frequency (clamped
// to 50..5000 Hz) and a duration in ms; the pin toggles every 1000000/(2f)
// ticks for 2*f*ms/1000 toggles (at least one), then drops low. Melody plays
// the NOTE_COUNT notes set over APB (frequency at 0x00..0x0C, duration at
// 0x10..0x1C). One word is worked at a time. A tick, stop, or dropped command
// goes from execute straight to emit; a command that starts a tone, including
// a tick that moves the melody to its next note, also passes through start,
// divide and commit, where the 20-step restoring divider computes the half
// period (the toggle count comes from one multiplier that runs alongside it
// and a reciprocal multiply done once it finishes). A result waiting on a stalled result channel does not hold
// off the next word; work on it finishes and waits for the output register.
module buzzer_tone_melody_player #(
  parameter int NOTE_COUNT = tbm_pkg::NOTE_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  tbm_item_if.sink                      item,
  tbm_result_if.source                  result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tbm_pkg::ADDR_W-1:0]    paddr,
  input  logic [tbm_pkg::DATA_W-1:0]    pwdata,
  output logic [tbm_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);

  tbm_pkg::freq_t    note_freq [tbm_pkg::NOTE_SLOTS];
  tbm_pkg::ms_t      note_ms   [tbm_pkg::NOTE_SLOTS];
  tbm_pkg::dp_cmd_t  cmd;
  tbm_pkg::dp_stat_t stat;

  logic                              wr_en;
  logic [tbm_pkg::REG_IDX_W-1:0]     reg_idx;
  logic [tbm_pkg::NOTE_W-1:0]        slot;

  // Register file: four frequencies, then four durations, one per 32-bit word.
  // Writes land on the access phase; no wait states.
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[tbm_pkg::ADDR_W-1:2];
  assign slot    = reg_idx[tbm_pkg::NOTE_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      note_freq <= tbm_pkg::NOTE_FREQ_RST;
      note_ms   <= tbm_pkg::NOTE_MS_RST;
    end else if (wr_en) begin
      if (reg_idx < tbm_pkg::REG_MS_FIRST) begin
        note_freq[slot] <= pwdata[tbm_pkg::FREQ_W-1:0];
      end else begin
        note_ms[slot] <= pwdata[tbm_pkg::MS_W-1:0];
      end
    end
  end

  always_comb begin
    if (reg_idx < tbm_pkg::REG_MS_FIRST) begin
      prdata = tbm_pkg::DATA_W'(note_freq[slot]);
    end else begin
      prdata = tbm_pkg::DATA_W'(note_ms[slot]);
    end
  end

  // Sequencer: accept one word, execute, for a new tone start / divide / commit, then emit.
  tbm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_ready (item.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Tone state, divider, toggle-count multipliers and the result register.
  tbm_dp #(
    .NOTE_COUNT (NOTE_COUNT)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .command       (item.command),
    .freq_hz       (item.freq_hz),
    .duration_ms   (item.duration_ms),
    .note_freq     (note_freq),
    .note_ms       (note_ms),
    .out_ready     (result.ready),
    .out_valid     (result.valid),
    .pin_level     (result.pin_level),
    .busy_res      (result.busy_res),
    .melody_active (result.melody_active),
    .note_index    (result.note_index),
    .ignored       (result.ignored)
  );

  // One word in flight: ready must drop right after an accept.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (item.valid && item.ready) |=> !item.ready)
    else $error("item accepted while another word is in work");

  // Note index is meaningful only while a melody runs.
  a_note_idle: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.melody_active) |-> (result.note_index == '0))
    else $error("note index nonzero with no melody");

  // A dropped command only happens against a sounding tone or running melody.
  a_ign_cause: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.ignored) |-> (result.busy_res || result.melody_active))
    else $error("command dropped while idle");

  // Emit always loads the result register.
  a_emit_loads: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> result.valid)
    else $error("result lost on emit");

endmodule
